// File: rtl/b6cf_pkg.sv
// shared types and constants for the six-bit character framer
package b6cf_pkg;

    localparam logic [7:0] MARK_CHAR   = 8'hFE;
    localparam logic [7:0] PAYLOAD_TAG = 8'h80;
    localparam logic [7:0] SIX_MASK    = 8'h3F;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_EMPTY = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    localparam int GROUP_W = 24;
    localparam int HELD_W  = 16;
    localparam int NCHAR_W = 3;

    localparam logic [NCHAR_W-1:0] NCHAR_ONE  = 3'd1;
    localparam logic [NCHAR_W-1:0] NCHAR_ONEB = 3'd2;
    localparam logic [NCHAR_W-1:0] NCHAR_TWOB = 3'd3;
    localparam logic [NCHAR_W-1:0] NCHAR_FULL = 3'd4;

    typedef struct packed {
        logic               start;
        logic [GROUP_W-1:0] group;
        logic [NCHAR_W-1:0] nchar;
        logic               close;
    } t_job;

endpackage

// File: rtl/b6cf_front.sv
// front end: takes input words, gathers byte groups and issues character jobs
module b6cf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_command,
    input  logic [7:0]      i_data_byte,
    input  logic            i_is_last,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output b6cf_pkg::t_job  o_job
);

    logic [b6cf_pkg::HELD_W-1:0] r_held;
    logic [b6cf_pkg::HELD_W-1:0] n_held;
    logic [1:0]                  r_count;
    logic [1:0]                  n_count;
    logic                        r_in_frame;
    logic                        n_in_frame;
    logic                        accept;
    b6cf_pkg::t_job              job;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        job        = '0;
        n_held     = r_held;
        n_count    = r_count;
        n_in_frame = r_in_frame;
        if (i_command == b6cf_pkg::CMD_EMPTY) begin
            job.start  = 1'b1;
            job.close  = 1'b1;
            n_held     = '0;
            n_count    = 2'd0;
            n_in_frame = 1'b0;
        end else begin
            job.start  = !r_in_frame;
            n_in_frame = 1'b1;
            case (r_count)
                2'd0: begin
                    n_held  = {8'h00, i_data_byte};
                    n_count = 2'd1;
                end
                2'd1: begin
                    n_held  = {i_data_byte, r_held[7:0]};
                    n_count = 2'd2;
                end
                default: begin
                    job.group = {i_data_byte, r_held};
                    job.nchar = b6cf_pkg::NCHAR_FULL;
                    n_held    = '0;
                    n_count   = 2'd0;
                end
            endcase
            if (i_is_last) begin
                if (n_count == 2'd1) begin
                    job.group = {16'h0000, n_held[7:0]};
                    job.nchar = b6cf_pkg::NCHAR_ONEB;
                end else if (n_count == 2'd2) begin
                    job.group = {8'h00, n_held};
                    job.nchar = b6cf_pkg::NCHAR_TWOB;
                end
                job.close  = 1'b1;
                n_held     = '0;
                n_count    = 2'd0;
                n_in_frame = 1'b0;
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.start || job.close || (job.nchar != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_count    <= 2'd0;
            r_in_frame <= 1'b0;
        end else if (accept) begin
            r_held     <= n_held;
            r_count    <= n_count;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// File: rtl/b6cf_queue.sv
// short job queue between front and back end
module b6cf_queue #(
    parameter int P_DEPTH = b6cf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b6cf_pkg::t_job  i_job,
    input  logic            i_pop,
    output b6cf_pkg::t_job  o_job,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    b6cf_pkg::t_job     r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/b6cf_back.sv
// back end: walks each job and sends one character word per cycle while the output is not stalled
module b6cf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b6cf_pkg::t_job  i_job,
    input  logic            i_q_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_frame_end
);

    logic                           r_busy;
    logic                           n_busy;
    logic                           r_start;
    logic                           n_start;
    logic [b6cf_pkg::NCHAR_W-1:0]   r_left;
    logic [b6cf_pkg::NCHAR_W-1:0]   n_left;
    logic                           r_close;
    logic                           n_close;
    logic [b6cf_pkg::GROUP_W-1:0]   r_group;
    logic [b6cf_pkg::GROUP_W-1:0]   n_group;
    logic                           r_out_valid;
    logic [7:0]                     r_out_char;
    logic                           r_frame_end;
    logic [7:0]                     emit_char;
    logic                           emit_end;
    logic                           emit;
    logic                           load;

    assign emit = r_busy && (!r_out_valid || !i_stall);

    always_comb begin
        n_start   = r_start;
        n_left    = r_left;
        n_close   = r_close;
        n_group   = r_group;
        n_busy    = r_busy;
        emit_char = b6cf_pkg::MARK_CHAR;
        emit_end  = 1'b0;
        if (emit) begin
            if (r_start) begin
                n_start = 1'b0;
            end else if (r_left != '0) begin
                emit_char = b6cf_pkg::PAYLOAD_TAG | (r_group[7:0] & b6cf_pkg::SIX_MASK);
                n_group   = r_group >> 6;
                n_left    = r_left - b6cf_pkg::NCHAR_ONE;
            end else begin
                emit_end = 1'b1;
                n_close  = 1'b0;
            end
        end
        load = !r_busy || (emit && !n_start && (n_left == '0) && !n_close);
        if (load) begin
            n_busy  = !i_q_empty;
            n_start = i_job.start;
            n_left  = i_job.nchar;
            n_close = i_job.close;
            n_group = i_job.group;
        end
    end

    assign o_pop = load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_left      <= '0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_start <= n_start;
            r_left  <= n_left;
            r_close <= n_close;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_group <= n_group;
        if (emit) begin
            r_out_char  <= emit_char;
            r_frame_end <= emit_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_frame_end = r_frame_end;

endmodule

// File: rtl/byte_to_six_bit_char_framer_unit.sv
// top level of the six-bit character framer
//
// A new input word can be taken every cycle while the job queue has room
// (P_QUEUE_DEPTH entries); o_stall rises only when it is full. The back end
// sends one character per cycle while i_stall is low, so the output port sets
// the sustained rate: four characters per three data bytes, plus one start
// and one closing marker per frame. A byte that completes no group gives
// nothing out. The first character of a job passes through the job queue,
// the back end's job registers and the output register before it appears.
module byte_to_six_bit_char_framer_unit #(
    parameter int P_QUEUE_DEPTH = b6cf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic        o_frame_end
);

    b6cf_pkg::t_job push_job;
    b6cf_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    b6cf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    b6cf_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    b6cf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_frame_end (o_frame_end)
    );

endmodule

// File: rtl/b6cf_checker.sv
// port-level checks for the six-bit character framer, bound to the top level
module b6cf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_out_char,
    input  logic        o_frame_end
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_frame_end))
        else $error("stalled output word changed");

    a_end_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_out_char == b6cf_pkg::MARK_CHAR)
        else $error("frame end without marker");

    a_char_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_char != b6cf_pkg::MARK_CHAR |-> o_out_char[7:6] == 2'b10)
        else $error("payload character out of range");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_frame_end |=> !(o_valid && o_frame_end))
        else $error("two frame ends in a row");

endmodule

bind byte_to_six_bit_char_framer_unit b6cf_checker u_b6cf_checker (.*);

// File: tb/sv/b6cf_char_check.sv
`timescale 1ns / 1ps
// checker for the six-bit character framer: predicts each character and compares the output stream
module b6cf_char_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_char,
    input  logic       i_frame_end,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_char;

    t_char       char_queue[$];
    t_char       want;
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    logic        frame_open;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held_bytes   = '0;
        held_count   = '0;
        frame_open   = 1'b0;
    end

    task automatic report(input string msg);
        $display("b6cf_char_check: %s (t=%0t)", msg, $time);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic add_char(input logic [7:0] ch, input logic fin);
        t_char c;
        c.ch  = ch;
        c.fin = fin;
        char_queue.push_back(c);
    endtask

    task automatic add_payload(input logic [23:0] bits, input int count);
        logic [23:0] sh;
        for (int k = 0; k < count; k++) begin
            sh = bits >> (6 * k);
            add_char(b6cf_pkg::PAYLOAD_TAG | (sh[7:0] & b6cf_pkg::SIX_MASK), 1'b0);
        end
    endtask

    task automatic predict_word(input logic cmd, input logic [7:0] b, input logic last);
        if (cmd == b6cf_pkg::CMD_EMPTY) begin
            add_char(b6cf_pkg::MARK_CHAR, 1'b0);
            add_char(b6cf_pkg::MARK_CHAR, 1'b1);
            held_bytes = '0;
            held_count = '0;
            frame_open = 1'b0;
        end else begin
            if (!frame_open) begin
                add_char(b6cf_pkg::MARK_CHAR, 1'b0);
                frame_open = 1'b1;
            end
            case (held_count)
                2'd0: begin
                    held_bytes = {8'h00, b};
                    held_count = 2'd1;
                end
                2'd1: begin
                    held_bytes[15:8] = b;
                    held_count       = 2'd2;
                end
                default: begin
                    add_payload({b, held_bytes}, 4);
                    held_bytes = '0;
                    held_count = '0;
                end
            endcase
            if (last) begin
                if (held_count == 2'd1) begin
                    add_payload({16'h0000, held_bytes[7:0]}, 2);
                end else if (held_count == 2'd2) begin
                    add_payload({8'h00, held_bytes}, 3);
                end
                add_char(b6cf_pkg::MARK_CHAR, 1'b1);
                held_bytes = '0;
                held_count = '0;
                frame_open = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_command, i_data_byte, i_is_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (char_queue.size() == 0) begin
                    report($sformatf("unexpected char %02h end %0b", i_out_char, i_frame_end));
                end else begin
                    want = char_queue.pop_front();
                    if (i_out_char !== want.ch) begin
                        report($sformatf("char %02h, wanted %02h", i_out_char, want.ch));
                    end
                    if (i_frame_end !== want.fin) begin
                        report($sformatf("frame_end %0b, wanted %0b on char %02h",
                                         i_frame_end, want.fin, want.ch));
                    end
                end
            end
            o_pending = char_queue.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the framer testbench: clock, reset, word stimulus, output stalls and the verdict
module tb_top;

    localparam int TOTAL_WORDS = 470;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_command   = b6cf_pkg::CMD_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_is_last   = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_frame_end;

    int   fail_count;
    int   pending;
    int   cycle_count  = 0;
    int   words_sent   = 0;
    logic sender_quiet = 1'b0;
    logic hold_trigger = 1'b0;

    byte_to_six_bit_char_framer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_frame_end (o_frame_end)
    );

    b6cf_char_check u_char_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .i_is_last    (i_is_last),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_char   (o_out_char),
        .i_frame_end  (o_frame_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_word(input logic cmd, input logic [7:0] b, input logic last);
        int gap;
        gap = sender_quiet ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        words_sent++;
        if (words_sent % 50 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
    endtask

    task automatic send_frame(input int len, input logic closed);
        for (int k = 0; k < len; k++) begin
            send_word(b6cf_pkg::CMD_DATA, 8'($urandom), closed && (k == len - 1));
        end
    endtask

    // output side stalls, with one long hold-off so the input backs up
    initial begin : receiver
        int   left;
        logic stall_now;
        logic quiet;
        logic held_off;
        left      = 0;
        stall_now = 1'b0;
        quiet     = 1'b0;
        held_off  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger && !held_off) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_now = 1'b0;
                left      = 0;
            end
            if (left == 0) begin
                if ($urandom_range(0, 15) == 0) quiet = !quiet;
                if (quiet || stall_now) begin
                    stall_now = 1'b0;
                    left      = $urandom_range(1, 12);
                end else begin
                    stall_now = 1'b1;
                    left      = 1 + idle_len();
                end
            end
            left--;
            i_stall <= stall_now;
        end
    end

    initial begin : stimulus
        int r;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words
        send_word(b6cf_pkg::CMD_EMPTY, 8'h00, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h00, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h00, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'hAA, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h55, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'h12, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h34, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h56, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h78, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'h11, 1'b0);
        send_word(b6cf_pkg::CMD_EMPTY, 8'hFF, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'h81, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h7E, 1'b0);
        send_word(b6cf_pkg::CMD_EMPTY, 8'h5A, 1'b0);
        send_word(b6cf_pkg::CMD_EMPTY, 8'hA5, 1'b1);
        send_word(b6cf_pkg::CMD_DATA,  8'h00, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h00, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'h00, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b0);
        send_word(b6cf_pkg::CMD_DATA,  8'hFF, 1'b1);

        // random frames, mostly well formed
        while (words_sent < TOTAL_WORDS) begin
            if (!hold_trigger && words_sent >= 150) hold_trigger = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 80) begin
                send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12), 1'b1);
            end else if (r < 90) begin
                send_frame($urandom_range(1, 8), 1'b0);
                send_word(b6cf_pkg::CMD_EMPTY, 8'($urandom), 1'($urandom));
            end else begin
                send_word(b6cf_pkg::CMD_EMPTY, 8'($urandom), 1'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
